/* design/tlsdf_pkg.sv */
// ----------------------------------------------------------------------------
// tlsdf_pkg: shared types and constants of the TLS record deframer
// Holds the result kind codes, the header byte positions and the content type range.
// ----------------------------------------------------------------------------
package tlsdf_pkg;

    // Tag that travels with every byte.
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_DISCARD = 2'd2
    } kind_t;

    // Position inside the 5-byte record header; IDX_PAYLOAD means payload.
    localparam int unsigned IDX_W = 3;
    typedef logic [IDX_W-1:0] hdr_idx_t;

    localparam hdr_idx_t IDX_TYPE    = 3'd0;
    localparam hdr_idx_t IDX_VER_HI  = 3'd1;
    localparam hdr_idx_t IDX_VER_LO  = 3'd2;
    localparam hdr_idx_t IDX_LEN_HI  = 3'd3;
    localparam hdr_idx_t IDX_LEN_LO  = 3'd4;
    localparam hdr_idx_t IDX_PAYLOAD = 3'd5;

    // Legal content types are 20 through 24.
    localparam logic [7:0] TYPE_MIN = 8'd20;
    localparam logic [7:0] TYPE_MAX = 8'd24;

endpackage

/* design/tls_record_deframer.sv */
// ----------------------------------------------------------------------------
// tls_record_deframer: byte-serial TLS record layer deframer
// Splits a TCP payload byte stream into record headers and payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one stream byte per transfer
//   together with a restart flag that clears all record state before that
//   byte is handled. The output channel (out_valid/out_ready) returns exactly
//   one result per input byte, in order: the byte, its tag (header, payload or
//   discarded), the fields of the current record, and the last_of_record and
//   type_error flags on the byte that completes a record.
//   Throughput is one byte per cycle while the receiver does not stall. An
//   input transfer reaches its result through the input register, then
//   the deframing logic updates the record state and loads the result
//   register. The record state advances only when a byte moves from the
//   input register into the result register.
//   When the receiver stalls, the result register holds its result and the
//   input register still takes one more byte if empty; after that in_ready drops
//   until the result is taken.
//   Reset empties both registers and clears the record state, so the first
//   byte after reset is treated as header byte 0 of a new record.
//   After a content type error every byte is tagged as discarded until a
//   byte arrives with restart set.
// ----------------------------------------------------------------------------
module tls_record_deframer
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        restart,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  byte_out,
    output logic [7:0]  content_type,
    output logic [15:0] record_version,
    output logic [15:0] record_length,
    output logic        last_of_record,
    output logic        type_error
);

    // Input register stage.
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_rst_reg;

    // Result register stage.
    logic                out_vld_reg;
    tlsdf_pkg::kind_t    kind_reg;
    logic [7:0]          byte_reg;
    logic [7:0]          type_out_reg;
    logic [15:0]         ver_out_reg;
    logic [15:0]         len_out_reg;
    logic                last_reg;
    logic                terr_reg;

    // Record state.
    tlsdf_pkg::hdr_idx_t idx_reg, idx_next;
    logic [7:0]          type_reg, type_next;
    logic [15:0]         ver_reg, ver_next;
    logic [15:0]         len_reg, len_next;
    logic [15:0]         left_reg, left_next;
    logic                halt_reg, halt_next;

    // Result of the byte now in the input register.
    tlsdf_pkg::kind_t    kind_next;
    logic                last_next;
    logic                terr_next;

    // Record state as seen by this byte, after an optional restart.
    tlsdf_pkg::hdr_idx_t eff_idx;
    logic [7:0]          eff_type;
    logic [15:0]         eff_ver;
    logic [15:0]         eff_len;
    logic [15:0]         eff_left;
    logic                eff_halt;
    logic [15:0]         left_dec;
    logic                done;

    logic advance;

    // The result register frees up when empty or when its result is taken;
    // the input register can then hand its byte over.
    assign advance  = !out_vld_reg || out_ready;
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
            in_rst_reg  <= restart;
        end
    end

    // Deframing step for the byte held in the input register.
    always_comb
    begin
        eff_idx  = in_rst_reg ? tlsdf_pkg::IDX_TYPE : idx_reg;
        eff_type = in_rst_reg ? 8'd0  : type_reg;
        eff_ver  = in_rst_reg ? 16'd0 : ver_reg;
        eff_len  = in_rst_reg ? 16'd0 : len_reg;
        eff_left = in_rst_reg ? 16'd0 : left_reg;
        eff_halt = in_rst_reg ? 1'b0  : halt_reg;

        idx_next  = eff_idx;
        type_next = eff_type;
        ver_next  = eff_ver;
        len_next  = eff_len;
        left_next = eff_left;
        halt_next = eff_halt;
        kind_next = tlsdf_pkg::KIND_PAYLOAD;
        last_next = 1'b0;
        terr_next = 1'b0;
        done      = 1'b0;
        left_dec  = (eff_left != 16'd0) ? (eff_left - 16'd1) : 16'd0;

        if (eff_halt)
        begin
            kind_next = tlsdf_pkg::KIND_DISCARD;
        end
        else if (eff_idx < tlsdf_pkg::IDX_PAYLOAD)
        begin
            kind_next = tlsdf_pkg::KIND_HEADER;
            unique case (eff_idx)
                tlsdf_pkg::IDX_TYPE:
                begin
                    type_next = in_byte_reg;
                    ver_next  = 16'd0;
                    len_next  = 16'd0;
                end
                tlsdf_pkg::IDX_VER_HI: ver_next = {in_byte_reg, 8'd0};
                tlsdf_pkg::IDX_VER_LO: ver_next = {eff_ver[15:8], in_byte_reg};
                tlsdf_pkg::IDX_LEN_HI: len_next = {in_byte_reg, 8'd0};
                default:               len_next = {eff_len[15:8], in_byte_reg};
            endcase
            if (eff_idx == tlsdf_pkg::IDX_LEN_LO)
            begin
                left_next = len_next;
                if (len_next == 16'd0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    idx_next = tlsdf_pkg::IDX_PAYLOAD;
                end
            end
            else
            begin
                idx_next = eff_idx + 3'd1;
            end
        end
        else
        begin
            // Index values above the payload code behave as payload.
            left_next = left_dec;
            done      = (left_dec == 16'd0);
        end

        if (done)
        begin
            last_next = 1'b1;
            idx_next  = tlsdf_pkg::IDX_TYPE;
            left_next = 16'd0;
            if (type_next < tlsdf_pkg::TYPE_MIN || type_next > tlsdf_pkg::TYPE_MAX)
            begin
                terr_next = 1'b1;
                halt_next = 1'b1;
            end
        end
    end

    // Record state moves on once per byte, when the byte leaves the input
    // register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= tlsdf_pkg::IDX_TYPE;
            type_reg    <= 8'd0;
            ver_reg     <= 16'd0;
            len_reg     <= 16'd0;
            left_reg    <= 16'd0;
            halt_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= in_vld_reg;
            if (in_vld_reg)
            begin
                idx_reg  <= idx_next;
                type_reg <= type_next;
                ver_reg  <= ver_next;
                len_reg  <= len_next;
                left_reg <= left_next;
                halt_reg <= halt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_vld_reg)
        begin
            kind_reg     <= kind_next;
            byte_reg     <= in_byte_reg;
            type_out_reg <= type_next;
            ver_out_reg  <= ver_next;
            len_out_reg  <= len_next;
            last_reg     <= last_next;
            terr_reg     <= terr_next;
        end
    end

    assign out_valid      = out_vld_reg;
    assign kind           = kind_reg;
    assign byte_out       = byte_reg;
    assign content_type   = type_out_reg;
    assign record_version = ver_out_reg;
    assign record_length  = len_out_reg;
    assign last_of_record = last_reg;
    assign type_error     = terr_reg;

endmodule

/* design/tlsdf_checker.sv */
// ----------------------------------------------------------------------------
// tlsdf_checker: port-level checks for the TLS record deframer
// Watches the result channel and flags results that cannot occur.
// ----------------------------------------------------------------------------
module tlsdf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [7:0]  byte_out,
    input logic        last_of_record,
    input logic        type_error
);

    // A type error is only reported on a byte that completes a record.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && type_error |-> last_of_record)
        else $error("type_error without last_of_record");

    // Discarded bytes never complete a record or report an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == tlsdf_pkg::KIND_DISCARD) |-> !last_of_record && !type_error)
        else $error("discarded byte carries record flags");

    // The tag is one of the three defined kinds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind != 2'd3))
        else $error("undefined result kind");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(kind))
        else $error("stalled result changed");

endmodule

bind tls_record_deframer tlsdf_checker u_tlsdf_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .byte_out       (byte_out),
    .last_of_record (last_of_record),
    .type_error     (type_error)
);
